>>> sv/chenc_pkg.sv
// shared types and constants for the cbor item head encoder
`default_nettype none

package chenc_pkg;

  // input opcodes
  localparam logic [3:0] OP_UINT    = 4'd0;
  localparam logic [3:0] OP_SINT    = 4'd1;
  localparam logic [3:0] OP_BYTES   = 4'd2;
  localparam logic [3:0] OP_TEXT    = 4'd3;
  localparam logic [3:0] OP_ARRAY   = 4'd4;
  localparam logic [3:0] OP_MAP     = 4'd5;
  localparam logic [3:0] OP_TAG     = 4'd6;
  localparam logic [3:0] OP_SIMPLE  = 4'd7;
  localparam logic [3:0] OP_PAYLOAD = 4'd8;
  localparam logic [3:0] OP_CLEAR   = 4'd9;

  // additional-info codes for the follow-on byte counts
  localparam logic [4:0] AI_ONE   = 5'd24;
  localparam logic [4:0] AI_TWO   = 5'd25;
  localparam logic [4:0] AI_FOUR  = 5'd26;
  localparam logic [4:0] AI_EIGHT = 5'd27;

  // stream widths
  localparam int IN_DATA_W  = 104;
  localparam int IN_USER_W  = 4;
  localparam int OUT_DATA_W = 48;

  // fill count and capacity width
  localparam int FILL_W   = 17;
  localparam int FILL_MAX = 2 ** FILL_W - 1;
  localparam int DEFAULT_MAX_CAPACITY = 65536;
  localparam logic [FILL_W-1:0] CAPACITY_RESET = 17'd256;

  // queue between front and back
  localparam int QUEUE_DEPTH = 4;

  typedef enum logic [1:0] {
    KIND_HEAD,
    KIND_PAYLOAD,
    KIND_CLEAR
  } kind_t;

  // one classified item as it travels from front to back
  typedef struct packed {
    kind_t       kind;
    logic [2:0]  major;
    logic [4:0]  ai;         // inline argument or follow-on code
    logic [3:0]  extra;      // follow-on byte count: 0, 1, 2, 4 or 8
    logic [63:0] arg;        // head argument, payload byte in the low bits
    logic        is_string;
    logic        arg_zero;
    logic        arg_small;  // argument fits in FILL_W bits
    logic [31:0] len_sat;    // string length saturated to 32 bits
  } entry_t;

endpackage

`default_nettype wire

>>> sv/chenc_front.sv
// front end: accepts input items and classifies them into queue entries
`default_nettype none

module chenc_front (
  input  wire logic                           s_tvalid,
  output logic                                s_tready,
  input  wire logic [chenc_pkg::IN_DATA_W-1:0] s_tdata,
  input  wire logic [chenc_pkg::IN_USER_W-1:0] s_tuser,
  input  wire logic                           q_full,
  output logic                                q_push,
  output chenc_pkg::entry_t                   q_entry
);
  import chenc_pkg::*;

  logic [63:0] argument;
  logic [31:0] signed_value;
  logic [7:0]  payload_byte;
  logic [63:0] head_arg;
  logic        keep;

  assign argument     = s_tdata[63:0];
  assign signed_value = s_tdata[95:64];
  assign payload_byte = s_tdata[103:96];

  // opcodes above clear are taken and dropped
  assign s_tready = !q_full;
  assign q_push   = s_tvalid && !q_full && keep;

  // opcode decode and head argument selection
  always_comb begin
    q_entry           = '0;
    q_entry.kind      = KIND_HEAD;
    q_entry.major     = s_tuser[2:0];
    head_arg          = argument;
    keep              = 1'b1;
    unique case (s_tuser)
      OP_SINT: begin
        if (signed_value[31]) begin
          q_entry.major = 3'd1;
          head_arg      = {32'd0, ~signed_value};
        end else begin
          q_entry.major = 3'd0;
          head_arg      = {32'd0, signed_value};
        end
      end
      OP_UINT, OP_BYTES, OP_TEXT, OP_ARRAY, OP_MAP, OP_TAG, OP_SIMPLE: begin
        head_arg = argument;
      end
      OP_PAYLOAD: begin
        q_entry.kind = KIND_PAYLOAD;
        head_arg     = {56'd0, payload_byte};
      end
      OP_CLEAR: begin
        q_entry.kind = KIND_CLEAR;
      end
      default: begin
        keep = 1'b0;
      end
    endcase

    q_entry.arg       = head_arg;
    q_entry.is_string = (s_tuser == OP_BYTES) || (s_tuser == OP_TEXT);
    q_entry.arg_zero  = (head_arg == 64'd0);
    q_entry.arg_small = (head_arg[63:FILL_W] == '0);
    q_entry.len_sat   = (head_arg[63:32] != 32'd0) ? 32'hFFFF_FFFF : head_arg[31:0];

    // argument size class
    if (head_arg[63:5] == '0 && head_arg[4:0] < 5'd24) begin
      q_entry.ai    = head_arg[4:0];
      q_entry.extra = 4'd0;
    end else if (head_arg[63:8] == '0) begin
      q_entry.ai    = AI_ONE;
      q_entry.extra = 4'd1;
    end else if (head_arg[63:16] == '0) begin
      q_entry.ai    = AI_TWO;
      q_entry.extra = 4'd2;
    end else if (head_arg[63:32] == '0) begin
      q_entry.ai    = AI_FOUR;
      q_entry.extra = 4'd4;
    end else begin
      q_entry.ai    = AI_EIGHT;
      q_entry.extra = 4'd8;
    end
  end

endmodule

`default_nettype wire

>>> sv/chenc_queue.sv
// short queue of classified items between front and back
`default_nettype none

module chenc_queue (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              push,
  input  wire chenc_pkg::entry_t push_entry,
  output logic                   full,
  input  wire logic              pop,
  output logic                   head_valid,
  output chenc_pkg::entry_t      head_entry
);
  import chenc_pkg::*;

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  entry_t             slots [QUEUE_DEPTH];
  logic [PTR_W-1:0]   wr_ptr;
  logic [PTR_W-1:0]   rd_ptr;
  logic [CNT_W-1:0]   count;

  assign full       = (count == CNT_W'(QUEUE_DEPTH));
  assign head_valid = (count != '0);
  assign head_entry = slots[rd_ptr];

  // entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

  // pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      count <= count + CNT_W'(push) - CNT_W'(pop);
    end
  end

endmodule

`default_nettype wire

>>> sv/chenc_back.sv
// back end: emits head and payload bytes and keeps the buffer fill count
`default_nettype none

module chenc_back #(
  parameter int MAX_CAPACITY = chenc_pkg::DEFAULT_MAX_CAPACITY
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             cfg_wen,
  input  wire logic [chenc_pkg::FILL_W-1:0]     cfg_wdata,
  input  wire logic                             q_valid,
  input  wire chenc_pkg::entry_t                q_entry,
  output logic                                  q_pop,
  output logic                                  m_tvalid,
  input  wire logic                             m_tready,
  output logic [chenc_pkg::OUT_DATA_W-1:0]      m_tdata,
  output logic                                  m_tlast
);
  import chenc_pkg::*;

  localparam logic [FILL_W-1:0] CAP_LIMIT =
    (MAX_CAPACITY > FILL_MAX) ? FILL_W'(FILL_MAX) : FILL_W'(MAX_CAPACITY);

  logic [FILL_W-1:0] capacity;
  logic [FILL_W-1:0] eff_cap;
  logic [FILL_W-1:0] fill_count, fill_count_next;
  logic [31:0]       payload_left, payload_left_next;
  logic              payload_fits, payload_fits_next;
  logic [3:0]        step, step_next;

  logic              can_emit;
  logic              fire;
  logic              emit;
  logic              allow;
  logic              wr_ok;
  logic [FILL_W-1:0] fill_inc;
  logic              last_byte;
  logic [3:0]        shift_bytes;
  logic [63:0]       arg_shifted;
  logic [7:0]        byte_val;
  logic [FILL_W:0]   end_pos;

  // capacity register
  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= CAPACITY_RESET;
    end else if (cfg_wen) begin
      capacity <= cfg_wdata;
    end
  end

  assign eff_cap = (capacity > CAP_LIMIT) ? CAP_LIMIT : capacity;

  // byte selection and storage decision
  always_comb begin
    can_emit    = !m_tvalid || m_tready;
    fire        = q_valid && ((q_entry.kind == KIND_CLEAR) || can_emit);
    emit        = fire && (q_entry.kind != KIND_CLEAR);
    shift_bytes = q_entry.extra - step;
    arg_shifted = q_entry.arg >> {shift_bytes[2:0], 3'b000};

    if (q_entry.kind == KIND_PAYLOAD) begin
      byte_val  = q_entry.arg[7:0];
      allow     = (payload_left != 32'd0) ? payload_fits : 1'b1;
      last_byte = 1'b1;
    end else begin
      byte_val  = (step == 4'd0) ? {q_entry.major, q_entry.ai} : arg_shifted[7:0];
      allow     = 1'b1;
      last_byte = (step == q_entry.extra);
    end

    wr_ok    = allow && (fill_count < eff_cap);
    fill_inc = fill_count + FILL_W'(wr_ok);
    end_pos  = {1'b0, fill_inc} + {1'b0, q_entry.arg[FILL_W-1:0]};
  end

  // item sequencing and buffer state update
  always_comb begin
    fill_count_next   = fill_count;
    payload_left_next = payload_left;
    payload_fits_next = payload_fits;
    step_next         = step;
    q_pop             = 1'b0;
    if (fire) begin
      unique case (q_entry.kind)
        KIND_HEAD: begin
          fill_count_next = fill_inc;
          if (last_byte) begin
            step_next = 4'd0;
            q_pop     = 1'b1;
            if (q_entry.is_string) begin
              payload_left_next = q_entry.len_sat;
              payload_fits_next = q_entry.arg_zero ||
                (q_entry.arg_small && (end_pos <= {1'b0, eff_cap}));
            end else begin
              payload_left_next = 32'd0;
              payload_fits_next = 1'b0;
            end
          end else begin
            step_next = step + 4'd1;
          end
        end
        KIND_PAYLOAD: begin
          fill_count_next = fill_inc;
          q_pop           = 1'b1;
          if (payload_left != 32'd0) begin
            payload_left_next = payload_left - 32'd1;
            if (payload_left == 32'd1) begin
              payload_fits_next = 1'b0;
            end
          end
        end
        KIND_CLEAR: begin
          fill_count_next   = '0;
          payload_left_next = 32'd0;
          payload_fits_next = 1'b0;
          q_pop             = 1'b1;
        end
        default: begin
          q_pop = 1'b1;
        end
      endcase
    end
  end

  // state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      fill_count   <= '0;
      payload_left <= 32'd0;
      payload_fits <= 1'b0;
      step         <= 4'd0;
    end else begin
      fill_count   <= fill_count_next;
      payload_left <= payload_left_next;
      payload_fits <= payload_fits_next;
      step         <= step_next;
    end
  end

  // output register: valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (emit) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  // output register: payload
  always_ff @(posedge clk) begin
    if (emit) begin
      m_tdata <= {6'd0, fill_inc, wr_ok, fill_count[15:0], byte_val};
      m_tlast <= last_byte;
    end
  end

`ifndef SYNTH
  // a stored byte moves the fill level one past its index
  a_written_level: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[24] |-> m_tdata[40:25] == m_tdata[23:8] + 16'd1)
    else $error("fill level does not follow a stored byte");

  // a dropped byte leaves the fill level at its index
  a_dropped_level: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tdata[24] |-> m_tdata[40:25] == m_tdata[23:8])
    else $error("fill level moved on a dropped byte");

  // byte step stays within the head being emitted
  a_step_range: assert property (@(posedge clk) disable iff (rst)
    q_valid && q_entry.kind == KIND_HEAD |-> step <= q_entry.extra)
    else $error("head byte step out of range");

  // step is back at zero when no item waits
  a_step_idle: assert property (@(posedge clk) disable iff (rst)
    !q_valid |-> step == 4'd0)
    else $error("byte step left open without an item");

  // a clear empties the buffer
  a_clear_empties: assert property (@(posedge clk) disable iff (rst)
    fire && q_entry.kind == KIND_CLEAR |=> fill_count == '0 && payload_left == 32'd0)
    else $error("clear did not empty the buffer");
`endif

endmodule

`default_nettype wire

>>> sv/cbor_item_head_encoder_unit.sv
// CBOR data item head encoder: top level
//
// Input stream (s_*): one transaction per item. s_tuser carries the opcode
// (uint, sint, byte-string head, text-string head, array, map, tag, simple,
// payload byte, clear); s_tdata carries argument, signed value and payload
// byte. Opcodes above clear are taken and discarded.
// Output stream (m_*): one transaction per encoded byte, with its buffer
// index, a stored/dropped flag and the fill level after it; m_tlast marks
// the final byte of an item. Clear produces no output.
// Configuration: cfg_wen/cfg_wdata load the buffer capacity (reset 256);
// write it only while the block is idle.
// Timing: an accepted item enters a four-entry queue; the emitter takes it
// from the queue head into the output register. The byte emitter puts out
// one byte per cycle while the output is not stalled; a payload byte is one
// byte and a head with an n-byte argument is 1+n bytes (1, 2, 3, 5 or 9);
// a clear emits no byte. Input is taken while the queue has room.
// Reset empties the queue, zeroes the fill count and open-string state.
// When m_tready is low the output register holds its byte, the emitter
// waits (clear items still pass) and the queue keeps taking items until full.
`default_nettype none

module cbor_item_head_encoder_unit #(
  parameter int MAX_CAPACITY = chenc_pkg::DEFAULT_MAX_CAPACITY
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  // capacity register write
  input  wire logic                             cfg_wen,
  input  wire logic [chenc_pkg::FILL_W-1:0]     cfg_wdata,
  // input items
  input  wire logic                             s_tvalid,
  output logic                                  s_tready,
  // argument[63:0], signed_value[95:64], payload_byte[103:96]
  input  wire logic [chenc_pkg::IN_DATA_W-1:0]  s_tdata,
  // opcode[3:0]
  input  wire logic [chenc_pkg::IN_USER_W-1:0]  s_tuser,
  // encoded bytes
  output logic                                  m_tvalid,
  input  wire logic                             m_tready,
  // out_byte[7:0], byte_index[23:8], written[24], fill_level[41:25], zero fill
  output logic [chenc_pkg::OUT_DATA_W-1:0]      m_tdata,
  output logic                                  m_tlast
);
  import chenc_pkg::*;

  logic   q_full;
  logic   q_push;
  entry_t q_push_entry;
  logic   q_pop;
  logic   q_valid;
  entry_t q_head;

  // classification
  chenc_front u_front (
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_entry  (q_push_entry)
  );

  // decoupling queue
  chenc_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (q_push),
    .push_entry (q_push_entry),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (q_valid),
    .head_entry (q_head)
  );

  // byte emitter and buffer accounting
  chenc_back #(
    .MAX_CAPACITY (MAX_CAPACITY)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg_wen   (cfg_wen),
    .cfg_wdata (cfg_wdata),
    .q_valid   (q_valid),
    .q_entry   (q_head),
    .q_pop     (q_pop),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast)
  );

endmodule

`default_nettype wire
